### hdl/pmf_pkg.sv
package pmf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_BITS  = 16;
    localparam int KEY_BITS    = SAMPLE_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + 3;
    localparam int COL_POINTS  = 3;
    localparam int NUM_POINTS  = 3 * COL_POINTS;
    localparam int RANK_BITS   = $clog2(NUM_POINTS + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    localparam int OLDER_BASE  = 0;
    localparam int MIDDLE_BASE = COL_POINTS;
    localparam int NEW_BASE    = 2 * COL_POINTS;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic signed [SUM_BITS-1:0] sum_t;
    typedef logic [RANK_BITS-1:0] rank_t;

    typedef struct packed {
        logic [NUM_POINTS-1:0]  present;
        sample_t [NUM_POINTS-1:0] pts;
        logic                   done;
    } window_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic                  done;
    } result_t;

    function automatic key_t key_of(input sample_t x, input logic mode);
        key_of = key_t'({mode & x[SAMPLE_BITS-1], x});
    endfunction

    function automatic rank_t count_bits(input logic [NUM_POINTS-1:0] v);
        rank_t n;
        n = '0;
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            n = n + rank_t'(v[i]);
        end
        count_bits = n;
    endfunction

endpackage

### hdl/pmf_window.sv
module pmf_window (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  pmf_pkg::sample_t   col [pmf_pkg::COL_POINTS],
    input  logic               ray_end,
    output logic               main_valid,
    output pmf_pkg::window_t   main_win,
    output logic               end_valid,
    output pmf_pkg::window_t   end_win
);

    pmf_pkg::sample_t older_reg  [pmf_pkg::COL_POINTS];
    pmf_pkg::sample_t middle_reg [pmf_pkg::COL_POINTS];
    logic [1:0]       held_reg;
    logic [1:0]       held_next;
    pmf_pkg::sample_t pts [pmf_pkg::NUM_POINTS];

    always_comb
    begin
        for (int i = 0; i < pmf_pkg::COL_POINTS; i++)
        begin
            pts[pmf_pkg::OLDER_BASE + i]  = older_reg[i];
            pts[pmf_pkg::MIDDLE_BASE + i] = middle_reg[i];
            pts[pmf_pkg::NEW_BASE + i]    = col[i];
        end
        for (int i = 0; i < pmf_pkg::NUM_POINTS; i++)
        begin
            main_win.pts[i] = pts[i];
            end_win.pts[i]  = pts[i];
        end
        main_win.done    = 1'b0;
        end_win.done     = 1'b1;
        main_win.present = '1;
        end_win.present  = '1;
        main_valid       = accept && (held_reg != pmf_pkg::HELD_NONE);
        end_valid        = accept && ray_end;
        for (int i = 0; i < pmf_pkg::COL_POINTS; i++)
        begin
            end_win.present[pmf_pkg::OLDER_BASE + i] = 1'b0;
            if (held_reg == pmf_pkg::HELD_NONE)
            begin
                end_win.present[pmf_pkg::MIDDLE_BASE + i] = 1'b0;
            end
            if (held_reg == pmf_pkg::HELD_ONE)
            begin
                main_win.present[pmf_pkg::OLDER_BASE + i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (ray_end)
        begin
            held_next = pmf_pkg::HELD_NONE;
        end
        else if (held_reg == pmf_pkg::HELD_NONE)
        begin
            held_next = pmf_pkg::HELD_ONE;
        end
        else
        begin
            held_next = pmf_pkg::HELD_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= pmf_pkg::HELD_NONE;
            for (int i = 0; i < pmf_pkg::COL_POINTS; i++)
            begin
                older_reg[i]  <= '0;
                middle_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            held_reg <= held_next;
            for (int i = 0; i < pmf_pkg::COL_POINTS; i++)
            begin
                if (ray_end)
                begin
                    older_reg[i]  <= '0;
                    middle_reg[i] <= '0;
                end
                else
                begin
                    older_reg[i]  <= middle_reg[i];
                    middle_reg[i] <= col[i];
                end
            end
        end
    end

endmodule

### hdl/pmf_lane.sv
module pmf_lane (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              mode,
    input  logic              in_valid,
    input  pmf_pkg::window_t  in_win,
    output logic              out_valid,
    output pmf_pkg::result_t  out_res
);

    localparam int N = pmf_pkg::NUM_POINTS;

    // stage 1: keys and pairwise order
    pmf_pkg::key_t   key_next    [N];
    logic [N-1:0]    before_next [N];
    logic [N-1:0]    nz_next;
    pmf_pkg::key_t   key_reg     [N];
    logic [N-1:0]    before_reg  [N];
    logic [N-1:0]    nz_reg;
    logic [N-1:0]    present_reg;
    logic            done1_reg;
    logic            valid1_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            key_next[i] = pmf_pkg::key_of(in_win.pts[i], mode);
            nz_next[i]  = in_win.present[i] && (in_win.pts[i] != '0);
        end
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                before_next[i][j] = nz_next[j] && ((key_next[j] < key_next[i]) ||
                                    ((key_next[j] == key_next[i]) && (j < i)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                key_reg[i]    <= key_next[i];
                before_reg[i] <= before_next[i];
            end
            nz_reg      <= nz_next;
            present_reg <= in_win.present;
            done1_reg   <= in_win.done;
        end
    end

    // stage 2: ranks and middle pick
    pmf_pkg::rank_t  nnz;
    pmf_pkg::rank_t  zeros;
    pmf_pkg::rank_t  lo_rank;
    pmf_pkg::rank_t  hi_rank;
    pmf_pkg::rank_t  rank     [N];
    pmf_pkg::key_t   lo_next;
    pmf_pkg::key_t   hi_next;
    pmf_pkg::key_t   lo_reg;
    pmf_pkg::key_t   hi_reg;
    logic            zero_reg;
    logic            odd_reg;
    logic            done2_reg;
    logic            valid2_reg;

    always_comb
    begin
        nnz     = pmf_pkg::count_bits(nz_reg);
        zeros   = pmf_pkg::count_bits(present_reg & ~nz_reg);
        lo_rank = (nnz - pmf_pkg::rank_t'(1)) >> 1;
        hi_rank = nnz >> 1;
        lo_next = '0;
        hi_next = '0;
        for (int i = 0; i < N; i++)
        begin
            rank[i] = pmf_pkg::count_bits(before_reg[i]);
            if (nz_reg[i] && (rank[i] == lo_rank))
            begin
                lo_next = lo_next | key_reg[i];
            end
            if (nz_reg[i] && (rank[i] == hi_rank))
            begin
                hi_next = hi_next | key_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            zero_reg  <= (zeros >= nnz);
            odd_reg   <= nnz[0];
            done2_reg <= done1_reg;
        end
    end

    // stage 3: mean of the two middle values, the middle value if odd, or zero
    pmf_pkg::sum_t    sum;
    pmf_pkg::sum_t    mid;
    pmf_pkg::result_t res_next;
    pmf_pkg::result_t res_reg;
    logic             valid3_reg;

    always_comb
    begin
        sum = pmf_pkg::sum_t'(lo_reg) + pmf_pkg::sum_t'(hi_reg);
        if (zero_reg)
        begin
            mid = '0;
        end
        else if (odd_reg)
        begin
            mid = pmf_pkg::sum_t'(lo_reg);
        end
        else if (sum >= 0)
        begin
            mid = (sum + pmf_pkg::sum_t'(1)) >>> 1;
        end
        else
        begin
            mid = -((pmf_pkg::sum_t'(1) - sum) >>> 1);
        end
        res_next.value = pmf_pkg::FIELD_BITS'(pmf_pkg::sample_t'(mid));
        res_next.done  = done2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    assign out_valid = valid3_reg;
    assign out_res   = res_reg;

endmodule

### hdl/pmf_merge.sv
module pmf_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_a,
    input  pmf_pkg::result_t  res_a,
    input  logic              push_b,
    input  pmf_pkg::result_t  res_b,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output pmf_pkg::result_t  out_res
);

    pmf_pkg::result_t                mem [pmf_pkg::FIFO_DEPTH];
    logic [pmf_pkg::PTR_BITS-1:0]    wr_ptr_reg;
    logic [pmf_pkg::PTR_BITS-1:0]    rd_ptr_reg;
    logic [pmf_pkg::CNT_BITS-1:0]    count_reg;
    logic [pmf_pkg::CNT_BITS-1:0]    count_next;
    logic [pmf_pkg::PTR_BITS-1:0]    wr_ptr_next;
    logic                            pop;
    logic [pmf_pkg::CNT_BITS-1:0]    n_push;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign room      = (count_reg <= pmf_pkg::CNT_BITS'(pmf_pkg::FIFO_DEPTH - 2));
    assign n_push    = pmf_pkg::CNT_BITS'(push_a) + pmf_pkg::CNT_BITS'(push_b);
    assign count_next  = count_reg + n_push - pmf_pkg::CNT_BITS'(pop);
    assign wr_ptr_next = wr_ptr_reg + pmf_pkg::PTR_BITS'(n_push);

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem[wr_ptr_reg] <= res_a;
            if (push_b)
            begin
                mem[wr_ptr_reg + pmf_pkg::PTR_BITS'(1)] <= res_b;
            end
        end
        else if (push_b)
        begin
            mem[wr_ptr_reg] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pmf_pkg::PTR_BITS'(1);
            end
        end
    end

endmodule

### hdl/polar_median_filter_3x3_top.sv
// Polar 3x3 median filter. Each request on s_* is one bin column (previous, current and next
// ray samples at that bin, ray wrap done by the feeder); s_tlast marks the last bin of a ray.
// A column is taken every clock while the output keeps up. The result for a bin appears after
// the following column arrives. Unless it also ends the ray, the first column of a ray yields
// no result; a later ray-end column yields two (the bin before it and the last bin, m_tlast high
// on the last). A ray of N bins therefore gives N results, and the input never stalls while
// m_tready stays high. From column to result the path runs through three stages in each of
// the two median lanes (pairwise compare, rank select, rounding mean) and the four-entry output
// queue. The lanes and the input stop while a lane result waits and the queue has fewer than
// two free entries. Zero samples count as invalid; cfg_data[0] selects signed samples and is to
// be written only while the block is idle; the block itself does not enforce this.
module polar_median_filter_3x3_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // prev_ray_sample, this_ray_sample, next_ray_sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // filtered_sample
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // sample_signed
);

    logic              signed_reg;
    logic              accept;
    logic              adv;
    logic              room;
    pmf_pkg::sample_t  col [pmf_pkg::COL_POINTS];
    logic              main_valid;
    logic              end_valid;
    pmf_pkg::window_t  main_win;
    pmf_pkg::window_t  end_win;
    logic              a_valid;
    logic              b_valid;
    pmf_pkg::result_t  a_res;
    pmf_pkg::result_t  b_res;
    pmf_pkg::result_t  out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            signed_reg <= cfg_data[0];
        end
    end

    assign adv      = !(a_valid || b_valid) || room;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign col[0] = pmf_pkg::sample_t'(s_tdata[15:0]);
    assign col[1] = pmf_pkg::sample_t'(s_tdata[31:16]);
    assign col[2] = pmf_pkg::sample_t'(s_tdata[47:32]);

    pmf_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .col        (col),
        .ray_end    (s_tlast),
        .main_valid (main_valid),
        .main_win   (main_win),
        .end_valid  (end_valid),
        .end_win    (end_win)
    );

    pmf_lane u_lane_main (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .mode      (signed_reg),
        .in_valid  (main_valid),
        .in_win    (main_win),
        .out_valid (a_valid),
        .out_res   (a_res)
    );

    pmf_lane u_lane_end (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .mode      (signed_reg),
        .in_valid  (end_valid),
        .in_win    (end_win),
        .out_valid (b_valid),
        .out_res   (b_res)
    );

    pmf_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (a_valid && adv),
        .res_a     (a_res),
        .push_b    (b_valid && adv),
        .res_b     (b_res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.value;
    assign m_tlast = out_res.done;

endmodule

### bench/polar_median_filter_3x3_top_tb.sv
module polar_median_filter_3x3_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 24;
    localparam int PHASE_COLUMNS = 280;

    class median_window_tracker;
        bit                signed_mode;
        pmf_pkg::sample_t  older[3];
        pmf_pkg::sample_t  middle[3];
        int                held;
        pmf_pkg::result_t  pending_medians[$];
        int                mismatches;
        int                results_checked;

        function new();
            signed_mode = 1'b0;
            held = 0;
            mismatches = 0;
            results_checked = 0;
            for (int i = 0; i < 3; i++)
            begin
                older[i] = '0;
                middle[i] = '0;
            end
        endfunction

        function longint sample_key(input pmf_pkg::sample_t x);
            if (signed_mode && x[pmf_pkg::SAMPLE_BITS-1])
                return longint'(x) - (longint'(1) << pmf_pkg::SAMPLE_BITS);
            return longint'(x);
        endfunction

        function pmf_pkg::sample_t window_median(input pmf_pkg::sample_t pts[9], input int n);
            longint vals[9];
            longint k;
            longint s;
            longint m;
            int nnz;
            int zeros;
            int j;
            nnz = 0;
            zeros = 0;
            for (int i = 0; i < n; i++)
            begin
                if (pts[i] == '0)
                    zeros++;
                else
                begin
                    k = sample_key(pts[i]);
                    j = nnz - 1;
                    while (j >= 0 && vals[j] > k)
                    begin
                        vals[j+1] = vals[j];
                        j--;
                    end
                    vals[j+1] = k;
                    nnz++;
                end
            end
            // zeros win on a majority, or on a tie when the point count is even
            if ((n % 2) == 0)
            begin
                if (2 * zeros >= n)
                    return '0;
            end
            else if (2 * zeros > n)
                return '0;
            if (nnz == 0)
                return '0;
            if (nnz % 2)
                m = vals[nnz/2];
            else
            begin
                s = vals[nnz/2-1] + vals[nnz/2];
                m = (s >= 0) ? (s + 1) / 2 : -((1 - s) / 2);
            end
            return pmf_pkg::sample_t'(m);
        endfunction

        function void push_median(input pmf_pkg::sample_t pts[9], input int n, input bit done);
            pmf_pkg::result_t r;
            r.value = window_median(pts, n);
            r.done = done;
            pending_medians.push_back(r);
        endfunction

        function void note_column(input pmf_pkg::sample_t col[3], input bit ray_end);
            pmf_pkg::sample_t pts[9];
            for (int i = 0; i < 9; i++)
                pts[i] = '0;
            if (held >= 2)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pts[i] = older[i];
                    pts[i+3] = middle[i];
                    pts[i+6] = col[i];
                end
                push_median(pts, 9, 1'b0);
            end
            else if (held == 1)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pts[i] = middle[i];
                    pts[i+3] = col[i];
                end
                push_median(pts, 6, 1'b0);
            end
            if (ray_end)
            begin
                // last bin: either a lone column or the edge window with the middle column
                if (held == 0)
                begin
                    for (int i = 0; i < 3; i++)
                        pts[i] = col[i];
                    push_median(pts, 3, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pts[i] = middle[i];
                        pts[i+3] = col[i];
                    end
                    push_median(pts, 6, 1'b1);
                end
                held = 0;
                for (int i = 0; i < 3; i++)
                begin
                    older[i] = '0;
                    middle[i] = '0;
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    older[i] = middle[i];
                    middle[i] = col[i];
                end
                held = (held >= 1) ? 2 : 1;
            end
        endfunction

        function void check_result(input logic [15:0] value, input logic done);
            pmf_pkg::result_t want;
            results_checked++;
            if (pending_medians.size() == 0)
            begin
                $error("unexpected result: filtered_sample %h ray_done %b", value, done);
                mismatches++;
                return;
            end
            want = pending_medians.pop_front();
            if (want.value !== value)
            begin
                $error("filtered_sample: expected %h, got %h", want.value, value);
                mismatches++;
            end
            if (want.done !== done)
            begin
                $error("ray_done: expected %b, got %b", want.done, done);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    median_window_tracker tracker = new();

    int cycle_count = 0;
    int columns_sent = 0;
    int rays_sent = 0;
    int burst_left = 0;
    int gap_limit = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int hold_cycles = 0;
    bit ready_level = 1'b1;

    polar_median_filter_3x3_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
                   tracker.pending_medians.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check accepted results, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tlast);
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(32, 200);
        end
        stall_left--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (hold_cycles == 0)
                begin
                    ready_level = !ready_level;
                    hold_cycles = ready_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
                end
                hold_cycles--;
                m_tready <= ready_level;
            end
        endcase
    end

    task automatic send_column(input pmf_pkg::sample_t prev_ray, input pmf_pkg::sample_t cur_ray,
                               input pmf_pkg::sample_t next_ray, input bit ray_end);
        int gap;
        pmf_pkg::sample_t col[3];
        if (burst_left == 0)
        begin
            gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {next_ray, cur_ray, prev_ray};
        s_tlast <= ray_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        col[0] = prev_ray;
        col[1] = cur_ray;
        col[2] = next_ray;
        tracker.note_column(col, ray_end);
        columns_sent++;
        if (ray_end)
            rays_sent++;
    endtask

    task automatic write_sample_mode(input bit signed_samples);
        s_tvalid <= 1'b0;
        while (tracker.pending_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= {7'd0, signed_samples};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.signed_mode = signed_samples;
    endtask

    task automatic run_directed();
        // lone column, one zero, extremes that straddle the sign bit
        send_column(16'hFFFF, 16'h0001, 16'h0000, 1'b1);
        // lone column with a zero majority
        send_column(16'h0000, 16'h0000, 16'h0005, 1'b1);
        // two-bin ray, both windows are edge windows
        send_column(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
        send_column(16'hFFFE, 16'hFFFF, 16'h0000, 1'b1);
        // all-zero column in the middle, edge window with exactly half zeros
        send_column(16'h0001, 16'h0002, 16'h0003, 1'b0);
        send_column(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_column(16'h0000, 16'h0000, 16'h0009, 1'b0);
        send_column(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_column(16'h7FFF, 16'hFFFF, 16'h0000, 1'b1);
        // inner windows with six and three zeros
        send_column(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_column(16'h0000, 16'h0000, 16'h0007, 1'b0);
        send_column(16'h0003, 16'h0000, 16'h0005, 1'b0);
        send_column(16'hFFFF, 16'hFFFE, 16'hFFFD, 1'b1);
        // full-scale ray
        send_column(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_column(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_column(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    function automatic pmf_pkg::sample_t random_sample(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct)
            return '0;
        case ($urandom_range(0, 11))
            0: return 16'hFFFF;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'h0001;
            4: return 16'h8001;
            default: return pmf_pkg::sample_t'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic run_random(input int n_columns);
        int sent;
        int ray_len;
        int zero_pct;
        sent = 0;
        while (sent < n_columns)
        begin
            case ($urandom_range(0, 9))
                0: ray_len = 1;
                1: ray_len = 2;
                2: ray_len = 3;
                default: ray_len = $urandom_range(4, 16);
            endcase
            zero_pct = ($urandom_range(0, 3) == 0) ? 55 : 15;
            // a phase may stop inside a ray, so the next mode sees held columns
            for (int i = 0; i < ray_len && sent < n_columns; i++)
            begin
                send_column(random_sample(zero_pct), random_sample(zero_pct),
                            random_sample(zero_pct), i == ray_len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_limit = 3;
        write_sample_mode(1'b0);
        run_directed();
        write_sample_mode(1'b1);
        run_directed();

        for (int phase = 0; phase < 4; phase++)
        begin
            gap_limit = (phase == 0) ? 0 : 6;
            burst_left = 0;
            write_sample_mode(phase % 2 == 0);
            run_random(PHASE_COLUMNS);
        end

        s_tvalid <= 1'b0;
        while (tracker.pending_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d columns in %0d complete rays, %0d results checked",
                 columns_sent, rays_sent, tracker.results_checked);
        $display("unsigned and signed samples, mode changes with columns held");
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
